FILE: rtl/ptnll_pkg.sv
// Package: shared types and constants of the Poisson template likelihood unit.
`timescale 1ns / 1ps
`default_nettype none
package ptnll_pkg;
    localparam int CNT_W     = 16;
    localparam int TMPL_W    = 32;
    localparam int WGT_W     = 20;
    localparam int PROD_W    = TMPL_W + WGT_W;
    localparam int ACC_W     = 58;
    localparam int PRED_W    = 40;
    localparam int SUM_W     = 64;
    localparam int MAX_LANES = 4;
    localparam int FRAC_BITS = 30;
    localparam int IN_W      = CNT_W + MAX_LANES * TMPL_W;
    localparam int OUT_W     = SUM_W + CNT_W;
    localparam logic [27:0] LN2_Q28 = 28'd186065279;

    // configuration register indexes
    localparam logic [2:0] CFG_TEMPLATES = 3'd0;
    localparam logic [2:0] CFG_WEIGHT_0  = 3'd1;
    localparam logic [2:0] CFG_WEIGHT_1  = 3'd2;
    localparam logic [2:0] CFG_WEIGHT_2  = 3'd3;
    localparam logic [2:0] CFG_WEIGHT_3  = 3'd4;

    typedef logic [WGT_W-1:0] weight_t;

    typedef struct packed {
        logic [PRED_W-1:0] pred;
        logic [CNT_W-1:0]  count;
        logic              last;
        logic              pred_sat;
    } bin_t;

    typedef enum logic [1:0] {FE_IDLE, FE_MAC, FE_PUSH} fe_state_t;

    typedef enum logic [2:0] {
        BE_IDLE, BE_NORM, BE_SQR, BE_LMUL, BE_LSUM, BE_CMUL, BE_ACC, BE_FIN
    } be_state_t;
endpackage
`default_nettype wire

FILE: rtl/ptnll_front.sv
// Front end: accepts bins and forms the weighted prediction, one lane a cycle.
`timescale 1ns / 1ps
`default_nettype none
module ptnll_front
    import ptnll_pkg::*;
#(
    parameter int LANES = 4
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,
    input  wire logic             s_tlast,
    input  wire logic [2:0]       templates_in_use,
    input  weight_t               weights [MAX_LANES],
    output logic                  push,
    output bin_t                  push_data,
    input  wire logic             q_full
);
    localparam logic [2:0] LANES_3 = 3'(LANES);

    fe_state_t           state_reg, state_next;
    logic [TMPL_W-1:0]   tmpl_reg [LANES];
    weight_t             wgt_reg [LANES];
    logic [2:0]          left_reg;
    logic [ACC_W-1:0]    acc_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                last_reg;
    logic [PROD_W-1:0]   prod;
    logic [ACC_W-1:0]    rounded;
    logic [ACC_W-17:0]   pre;
    logic                accept;

    assign prod    = tmpl_reg[0] * wgt_reg[0];
    assign rounded = acc_reg + ACC_W'(32768);
    assign pre     = rounded[ACC_W-1:16];
    assign accept  = s_tvalid && s_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            FE_IDLE: if (s_tvalid) state_next = FE_MAC;
            FE_MAC:  if (left_reg == 3'd0) state_next = FE_PUSH;
            FE_PUSH: if (!q_full) state_next = FE_IDLE;
            default: state_next = FE_IDLE;
        endcase
    end

    always_comb begin
        s_tready            = (state_reg == FE_IDLE);
        push                = (state_reg == FE_PUSH) && !q_full;
        push_data.count     = count_reg;
        push_data.last      = last_reg;
        push_data.pred_sat  = |pre[ACC_W-17:PRED_W];
        push_data.pred      = push_data.pred_sat ? {PRED_W{1'b1}} : pre[PRED_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= FE_IDLE;
        else          state_reg <= state_next;
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            for (int k = 0; k < LANES; k++) begin
                tmpl_reg[k] <= s_tdata[CNT_W + k*TMPL_W +: TMPL_W];
                wgt_reg[k]  <= weights[k];
            end
            left_reg  <= (templates_in_use > LANES_3) ? LANES_3 : templates_in_use;
            acc_reg   <= '0;
            count_reg <= s_tdata[CNT_W-1:0];
            last_reg  <= s_tlast;
        end else if (state_reg == FE_MAC && left_reg != 3'd0) begin
            acc_reg  <= acc_reg + {{(ACC_W-PROD_W){1'b0}}, prod};
            left_reg <= left_reg - 3'd1;
            for (int k = 0; k < LANES - 1; k++) begin
                tmpl_reg[k] <= tmpl_reg[k+1];
                wgt_reg[k]  <= wgt_reg[k+1];
            end
        end
    end
endmodule
`default_nettype wire

FILE: rtl/ptnll_queue.sv
// Two-entry queue between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module ptnll_queue
    import ptnll_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic push,
    input  bin_t      push_data,
    output logic      full,
    input  wire logic pop,
    output logic      not_empty,
    output bin_t      pop_data
);
    bin_t       mem_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] fill_reg;

    assign full      = (fill_reg == 2'd2);
    assign not_empty = (fill_reg != 2'd0);
    assign pop_data  = mem_reg[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) mem_reg[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            fill_reg   <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            if (push && !pop)      fill_reg <= fill_reg + 2'd1;
            else if (pop && !push) fill_reg <= fill_reg - 2'd1;
        end
    end
endmodule
`default_nettype wire

FILE: rtl/ptnll_back.sv
// Back end: iterative log, term, saturating accumulation and result register.
`timescale 1ns / 1ps
`default_nettype none
module ptnll_back
    import ptnll_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    input  bin_t                   q_data,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [OUT_W-1:0]       m_tdata,
    output logic                   m_tuser
);
    be_state_t                state_reg, state_next;
    logic [PRED_W-1:0]        x_reg, pred_reg;
    logic [5:0]               p_reg;
    logic [31:0]              m_reg;
    logic [FRAC_BITS-1:0]     frac_reg;
    logic [4:0]               it_reg;
    logic [CNT_W-1:0]         cnt_reg;
    logic                     last_reg;
    logic                     neg_reg;
    logic [45:0]              hi_reg, lo_reg;
    logic signed [23:0]       ln_reg;
    logic signed [40:0]       prod_reg;
    logic signed [SUM_W-1:0]  sum_reg;
    logic [CNT_W-1:0]         skip_reg;
    logic                     ovf_reg;
    logic                     out_valid_reg;
    logic [SUM_W-1:0]         out_nll_reg;
    logic [CNT_W-1:0]         out_skip_reg;
    logic                     out_sat_reg;

    logic                     load_out;
    logic [63:0]              sq;
    logic [32:0]              sq_q;
    logic signed [6:0]        pm;
    logic signed [36:0]       l2;
    logic [36:0]              mag;
    logic [64:0]              lsum;
    logic [21:0]              r;
    logic signed [SUM_W-1:0]  term, raw;
    logic [SUM_W-1:0]         twice;
    logic                     dbl_sat;

    assign sq   = m_reg * m_reg;
    assign sq_q = sq[63:31];
    assign pm   = $signed({1'b0, p_reg}) - 7'sd16;
    assign l2   = $signed({pm, {FRAC_BITS{1'b0}}}) + $signed({7'b0, frac_reg});
    assign mag  = l2[36] ? 37'(-l2) : 37'(l2);
    assign lsum = {1'b0, hi_reg, 18'b0} + {19'b0, lo_reg} + (65'd1 << 41);
    assign r    = lsum[63:42];
    assign term = $signed({24'b0, pred_reg}) - SUM_W'(prod_reg);
    assign raw  = sum_reg + term;

    always_comb begin
        dbl_sat = 1'b0;
        unique case (sum_reg[63:62])
            2'b01: begin twice = 64'h7FFF_FFFF_FFFF_FFFF; dbl_sat = 1'b1; end
            2'b10: begin twice = 64'h8000_0000_0000_0000; dbl_sat = 1'b1; end
            default: twice = {sum_reg[62:0], 1'b0};
        endcase
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            BE_IDLE: if (q_valid) state_next = (q_data.pred == '0) ? BE_FIN : BE_NORM;
            BE_NORM: if (x_reg[PRED_W-1]) state_next = BE_SQR;
            BE_SQR:  if (it_reg == 5'(FRAC_BITS - 1)) state_next = BE_LMUL;
            BE_LMUL: state_next = BE_LSUM;
            BE_LSUM: state_next = BE_CMUL;
            BE_CMUL: state_next = BE_ACC;
            BE_ACC:  state_next = BE_FIN;
            BE_FIN:  if (!last_reg || load_out) state_next = BE_IDLE;
            default: state_next = BE_IDLE;
        endcase
    end

    always_comb begin
        q_pop    = (state_reg == BE_IDLE) && q_valid;
        load_out = (state_reg == BE_FIN) && last_reg && (!out_valid_reg || m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) state_reg <= BE_IDLE;
        else          state_reg <= state_next;
    end

    // datapath of the log and term
    always_ff @(posedge aclk) begin
        unique case (state_reg)
            BE_IDLE: begin
                x_reg    <= q_data.pred;
                pred_reg <= q_data.pred;
                cnt_reg  <= q_data.count;
                last_reg <= q_data.last;
                p_reg    <= 6'd39;
            end
            BE_NORM: begin
                if (x_reg[PRED_W-1]) begin
                    m_reg    <= x_reg[PRED_W-1:8];
                    it_reg   <= '0;
                    frac_reg <= '0;
                end else begin
                    x_reg <= {x_reg[PRED_W-2:0], 1'b0};
                    p_reg <= p_reg - 6'd1;
                end
            end
            BE_SQR: begin
                frac_reg <= {frac_reg[FRAC_BITS-2:0], sq_q[32]};
                m_reg    <= sq_q[32] ? sq_q[32:1] : sq_q[31:0];
                it_reg   <= it_reg + 5'd1;
            end
            BE_LMUL: begin
                neg_reg <= l2[36];
                hi_reg  <= mag[35:18] * LN2_Q28;
                lo_reg  <= mag[17:0] * LN2_Q28;
            end
            BE_LSUM: ln_reg <= neg_reg ? -$signed({2'b0, r}) : $signed({2'b0, r});
            BE_CMUL: prod_reg <= $signed({1'b0, cnt_reg}) * ln_reg;
            default: ;
        endcase
    end

    // running state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg  <= '0;
            skip_reg <= '0;
            ovf_reg  <= 1'b0;
        end else if (q_pop) begin
            if (q_data.pred_sat) ovf_reg <= 1'b1;
            if (q_data.pred == '0 && skip_reg != '1) skip_reg <= skip_reg + 16'd1;
        end else if (state_reg == BE_ACC) begin
            if (!sum_reg[63] && !term[63] && raw[63]) begin
                sum_reg <= 64'sh7FFF_FFFF_FFFF_FFFF;
                ovf_reg <= 1'b1;
            end else if (sum_reg[63] && term[63] && !raw[63]) begin
                sum_reg <= 64'sh8000_0000_0000_0000;
                ovf_reg <= 1'b1;
            end else begin
                sum_reg <= raw;
            end
        end else if (load_out) begin
            sum_reg  <= '0;
            skip_reg <= '0;
            ovf_reg  <= 1'b0;
        end
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load_out) begin
            out_nll_reg  <= twice;
            out_skip_reg <= skip_reg;
            out_sat_reg  <= ovf_reg | dbl_sat;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_skip_reg, out_nll_reg};
    assign m_tuser  = out_sat_reg;
endmodule
`default_nettype wire

FILE: rtl/poisson_template_nll_unit.sv
// Top level: binned Poisson template likelihood unit with its register file.
//
// Input beats on s_*: one histogram bin per beat, s_tlast marks the final bin.
// A result beat on m_* follows each final bin: twice the summed negative log
// likelihood (signed Q47.16), the count of zero-prediction bins, and in m_tuser
// a flag set if any prediction or the sum saturated.
// Registers are written through cfg_we / cfg_index / cfg_data, one per edge;
// the user must do so only while the unit is idle, which it does not enforce.
// Index 0 is the template count, 1 to 4 the weights.
// The front end takes a bin, runs one template in use a cycle on the shared
// 32x20 multiplier, rounds, then pushes the prediction into a two-entry queue.
// The back end pops a bin, runs the leading-one search and the squaring loop
// of the logarithm, then scaling, term, sum and the final step; its time per
// bin is set by the leading-one search and the squaring loop, and it pops the
// next bin only after the final step. A skipped bin goes from the pop straight
// to the final step.
// A stalled result holds in the output register; the back end waits on it and
// the queue and front end go on taking bins until they fill.
// Synchronous reset clears the running sum, skip count, flag and the queue,
// and sets the template count to 1 and all weights to 1.0.
`timescale 1ns / 1ps
`default_nettype none
module poisson_template_nll_unit
    import ptnll_pkg::*;
#(
    parameter int TEMPLATES = 4
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    // observed_count[15:0], template_0..template_3 at 32 bits each above it
    input  wire logic [IN_W-1:0]   s_tdata,
    input  wire logic              s_tlast,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    // nll_value[63:0], skipped_bins[79:64]
    output logic [OUT_W-1:0]       m_tdata,
    // saturated
    output logic                   m_tuser,
    input  wire logic              cfg_we,
    input  wire logic [2:0]        cfg_index,
    input  wire logic [WGT_W-1:0]  cfg_data
);
    localparam int LANES = (TEMPLATES < MAX_LANES) ? TEMPLATES : MAX_LANES;

    logic [2:0] tiu_reg;
    weight_t    wgt_reg [MAX_LANES];
    logic       push, q_full, q_pop, q_valid;
    bin_t       push_data, q_data;

    // register file
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tiu_reg <= 3'd1;
            for (int k = 0; k < MAX_LANES; k++) wgt_reg[k] <= WGT_W'(65536);
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_TEMPLATES: tiu_reg    <= cfg_data[2:0];
                CFG_WEIGHT_0:  wgt_reg[0] <= cfg_data;
                CFG_WEIGHT_1:  wgt_reg[1] <= cfg_data;
                CFG_WEIGHT_2:  wgt_reg[2] <= cfg_data;
                CFG_WEIGHT_3:  wgt_reg[3] <= cfg_data;
                default: ;
            endcase
        end
    end

    ptnll_front #(.LANES(LANES)) u_front (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_tvalid         (s_tvalid),
        .s_tready         (s_tready),
        .s_tdata          (s_tdata),
        .s_tlast          (s_tlast),
        .templates_in_use (tiu_reg),
        .weights          (wgt_reg),
        .push             (push),
        .push_data        (push_data),
        .q_full           (q_full)
    );

    ptnll_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data (push_data),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_valid),
        .pop_data  (q_data)
    );

    ptnll_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_data   (q_data),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    // no result straight after reset
    a_reset_quiet: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result beat right after reset");

    // an unsaturated result is twice a sum, hence even
    a_even: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tuser |-> !m_tdata[0])
        else $error("odd result without saturation");

    // the positive limit is only reached through saturation
    a_max_sat: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[63:0] == 64'h7FFF_FFFF_FFFF_FFFF |-> m_tuser)
        else $error("positive limit without saturation flag");
endmodule
`default_nettype wire

FILE: bench/testbench.sv
// Testbench: the Poisson template likelihood unit against its own model.
`timescale 1ns / 1ps
`default_nettype none
module testbench;
    import ptnll_pkg::*;

    localparam int  TMPL_LANES = 4;
    localparam int  BIN_TARGET = 1800;
    localparam int  STALL_MAX  = 20000;   // cycles without a beat before giving up
    localparam int  SETTLE     = 100;     // wait after each drain, long enough for the back end to settle

    typedef struct {
        logic signed [SUM_W-1:0] nll;
        logic [CNT_W-1:0]        skipped;
        logic                    sat;
    } frame_result_t;

    // Model of the unit plus the queue of frame results it still owes.
    class nll_scoreboard;
        logic [2:0]          tmpl_cnt;
        logic [WGT_W-1:0]    wgt [TMPL_LANES];
        longint              run_sum;
        int                  skips;
        bit                  ovf;
        frame_result_t       owed [$];
        int                  errors;
        int                  checked;

        function new();
            tmpl_cnt = 3'd1;
            foreach (wgt[i]) wgt[i] = 20'h10000;
            run_sum = 0;
            skips   = 0;
            ovf     = 0;
            errors  = 0;
            checked = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [WGT_W-1:0] val);
            case (idx)
                CFG_TEMPLATES: tmpl_cnt = val[2:0];
                CFG_WEIGHT_0:  wgt[0] = val;
                CFG_WEIGHT_1:  wgt[1] = val;
                CFG_WEIGHT_2:  wgt[2] = val;
                CFG_WEIGHT_3:  wgt[3] = val;
                default: ;      // unknown index: no effect
            endcase
        endfunction

        // natural log of a nonzero Q24.16 value, signed Q.16
        function longint ln_q16(longint unsigned x);
            int                p;
            longint unsigned   m, frac, mag, r;
            longint            l2;
            p = 39;
            while (p > 0 && x[p] == 1'b0) p--;
            m = (p > 31) ? (x >> (p - 31)) : (x << (31 - p));
            frac = 0;
            for (int i = 0; i < FRAC_BITS; i++) begin
                m = (m * m) >> 31;
                frac = frac << 1;
                if (m >= 64'h1_0000_0000) begin
                    frac = frac | 64'd1;
                    m = m >> 1;
                end
            end
            l2  = longint'(p - 16) * (64'sd1 <<< FRAC_BITS) + longint'(frac);
            mag = (l2 < 0) ? longint'(-l2) : l2;
            r   = (mag * 64'd186065279 + (64'd1 << 41)) >> 42;
            return (l2 < 0) ? -longint'(r) : longint'(r);
        endfunction

        function void note_bin(logic [IN_W-1:0] beat, logic last);
            int                lanes;
            longint unsigned   acc, pred;
            longint            term, nxt, twice;
            frame_result_t     res;
            lanes = (tmpl_cnt > TMPL_LANES) ? TMPL_LANES : int'(tmpl_cnt);
            acc = 0;
            for (int i = 0; i < lanes; i++)
                acc += longint'(beat[CNT_W + i*TMPL_W +: TMPL_W]) * longint'(wgt[i]);
            pred = (acc + 64'h8000) >> 16;
            if (pred > 64'hFF_FFFF_FFFF) begin
                pred = 64'hFF_FFFF_FFFF;
                ovf  = 1;
            end
            if (pred == 0) begin
                if (skips < 65535) skips++;
            end else begin
                term = longint'(pred) - longint'(beat[CNT_W-1:0]) * ln_q16(pred);
                nxt  = run_sum + term;
                if (term > 0 && nxt < run_sum) begin
                    nxt = 64'sh7FFF_FFFF_FFFF_FFFF;
                    ovf = 1;
                end else if (term < 0 && nxt > run_sum) begin
                    nxt = 64'sh8000_0000_0000_0000;
                    ovf = 1;
                end
                run_sum = nxt;
            end
            if (!last) return;
            if (run_sum > 64'sh3FFF_FFFF_FFFF_FFFF) begin
                twice = 64'sh7FFF_FFFF_FFFF_FFFF;
                ovf   = 1;
            end else if (run_sum < 64'shC000_0000_0000_0000) begin
                twice = 64'sh8000_0000_0000_0000;
                ovf   = 1;
            end else begin
                twice = run_sum * 2;
            end
            res.nll     = twice;
            res.skipped = skips[CNT_W-1:0];
            res.sat     = ovf;
            owed.push_back(res);
            run_sum = 0;
            skips   = 0;
            ovf     = 0;
        endfunction

        function void check_result(logic [OUT_W-1:0] beat, logic flag);
            frame_result_t want;
            if (owed.size() == 0) begin
                $display("%0t: unexpected result beat nll=%0d skipped=%0d sat=%0b",
                         $time, $signed(beat[SUM_W-1:0]), beat[OUT_W-1:SUM_W], flag);
                errors++;
                return;
            end
            want = owed.pop_front();
            checked++;
            if (beat[SUM_W-1:0] !== want.nll) begin
                $display("%0t: nll_value expected %0d actual %0d", $time, want.nll,
                         $signed(beat[SUM_W-1:0]));
                errors++;
            end
            if (beat[OUT_W-1:SUM_W] !== want.skipped) begin
                $display("%0t: skipped_bins expected %0d actual %0d", $time,
                         want.skipped, beat[OUT_W-1:SUM_W]);
                errors++;
            end
            if (flag !== want.sat) begin
                $display("%0t: saturated expected %0b actual %0b", $time, want.sat, flag);
                errors++;
            end
        endfunction
    endclass

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              s_tvalid = 1'b0;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata = '0;
    logic              s_tlast = 1'b0;
    logic              m_tvalid;
    logic              m_tready = 1'b0;
    logic [OUT_W-1:0]  m_tdata;
    logic              m_tuser;
    logic              cfg_we = 1'b0;
    logic [2:0]        cfg_index = CFG_TEMPLATES;
    logic [WGT_W-1:0]  cfg_data = '0;

    nll_scoreboard     nll_sb;
    int                bins_sent = 0;
    int                cfg_writes = 0;
    int                quiet_cycles = 0;
    bit                calm = 0;        // no idling on either side while set

    poisson_template_nll_unit #(.TEMPLATES(TMPL_LANES)) DUT (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tlast(s_tlast),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Sink side: back-pressure in about 18% of cycles unless calm.
    always @(posedge aclk) begin
        m_tready <= calm || ($urandom_range(0, 99) >= 18);
    end

    // Handshakes are decided by values that only move at the rising edge,
    // so the midpoint of the cycle sees what the next edge will accept.
    always @(negedge aclk) begin
        if (aresetn && s_tvalid && s_tready) nll_sb.note_bin(s_tdata, s_tlast);
        if (aresetn && m_tvalid && m_tready) nll_sb.check_result(m_tdata, m_tuser);
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= STALL_MAX) begin
            $display("%0t: no beat for %0d cycles", $time, STALL_MAX);
            $display("Test completed with failures");
            $finish;
        end
    end

    // Writes of one group follow back to back; end_writes drops the enable.
    task automatic write_reg(logic [2:0] idx, logic [WGT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge aclk);
        nll_sb.write_reg(idx, val);
        cfg_writes++;
    endtask

    task automatic end_writes();
        cfg_we <= 1'b0;
    endtask

    // Drop valid, wait for the owed results to drain, then settle the back end.
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (nll_sb.owed.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic send_bin(logic [CNT_W-1:0] cnt, logic [TMPL_W-1:0] t0,
                            logic [TMPL_W-1:0] t1, logic [TMPL_W-1:0] t2,
                            logic [TMPL_W-1:0] t3, logic last);
        bit ready_seen;
        if (!calm && $urandom_range(0, 99) < 18) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {t3, t2, t1, t0, cnt};
        s_tlast  <= last;
        do begin
            @(negedge aclk);
            ready_seen = s_tready;
            @(posedge aclk);
        end while (!ready_seen);
        bins_sent++;
    endtask

    function automatic logic [TMPL_W-1:0] rand_tmpl();
        case ($urandom_range(0, 9))
            0, 1:    return '0;
            2:       return '1;
            3, 4, 5: return $urandom_range(0, 32'h3_FFFF);   // up to a few units
            6:       return $urandom_range(0, 32'h3F);       // well below one
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [CNT_W-1:0] rand_count();
        case ($urandom_range(0, 5))
            0:       return '0;
            1:       return '1;
            2, 3:    return CNT_W'($urandom_range(0, 40));
            default: return CNT_W'($urandom());
        endcase
    endfunction

    function automatic logic [WGT_W-1:0] rand_weight();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;                  // above ten, used as is
            2:       return 20'hA0000;           // exactly ten
            3:       return WGT_W'($urandom_range(0, 20'h2));
            default: return WGT_W'($urandom());
        endcase
    endfunction

    initial begin
        int nframes, nbins;
        nll_sb = new();
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: reset config, single template at weight one.
        send_bin(16'd0, 32'h0001_0000, 32'h0, 32'h0, 32'h0, 1'b0);    // pred one, ln zero
        send_bin(16'hFFFF, 32'h0000_0001, 32'h0, 32'h0, 32'h0, 1'b0); // smallest prediction
        send_bin(16'd5, 32'h0, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b0);   // zero pred, skipped
        send_bin(16'hFFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 32'h0, 1'b0);
        send_bin(16'd3, 32'h0000_8000, 32'h0, 32'h0, 32'h0, 1'b1);   // pred one half
        send_bin(16'd7, 32'h0, 32'h0, 32'h0, 32'h0, 1'b1);           // frame of one skip
        drain();

        // All lanes, weights above ten: largest templates, largest prediction for these weights.
        write_reg(CFG_TEMPLATES, 20'd4);
        write_reg(CFG_WEIGHT_0, 20'hFFFFF);
        write_reg(CFG_WEIGHT_1, 20'hFFFFF);
        write_reg(CFG_WEIGHT_2, 20'hFFFFF);
        write_reg(CFG_WEIGHT_3, 20'hFFFFF);
        end_writes();
        send_bin(16'hFFFF, '1, '1, '1, '1, 1'b0);
        send_bin(16'd0, '1, '1, '1, '1, 1'b0);
        send_bin(16'd1, 32'h1, 32'h0, 32'h0, 32'h1, 1'b1);
        drain();

        // Template count zero: every bin skipped; unknown indexes ignored.
        write_reg(CFG_TEMPLATES, 20'd0);
        write_reg(3'd5, 20'hFFFFF);
        write_reg(3'd7, 20'h12345);
        end_writes();
        send_bin(16'd9, '1, '1, '1, '1, 1'b0);
        send_bin(16'd9, '1, '1, '1, '1, 1'b1);
        drain();

        // Template count above the lane count, weights zero and ten.
        write_reg(CFG_TEMPLATES, 20'd7);
        write_reg(CFG_WEIGHT_0, 20'd0);
        write_reg(CFG_WEIGHT_3, 20'hA0000);
        end_writes();
        send_bin(16'd2, '1, 32'h0, 32'h0, 32'h0001_0000, 1'b0);
        send_bin(16'd100, 32'h5, 32'hFFFF_FFFF, 32'h3, 32'h0, 1'b1);
        drain();

        // Random phases: new settings, then a few frames of random bins.
        while (bins_sent < BIN_TARGET) begin
            write_reg(CFG_TEMPLATES, 20'($urandom_range(0, 7)));
            write_reg(CFG_WEIGHT_0, rand_weight());
            write_reg(CFG_WEIGHT_1, rand_weight());
            write_reg(CFG_WEIGHT_2, rand_weight());
            write_reg(CFG_WEIGHT_3, rand_weight());
            end_writes();
            nframes = $urandom_range(1, 4);
            for (int f = 0; f < nframes; f++) begin
                nbins = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(1, 12);
                for (int b = 0; b < nbins; b++) begin
                    calm = (bins_sent >= 700 && bins_sent < 1000);
                    send_bin(rand_count(), rand_tmpl(), rand_tmpl(), rand_tmpl(),
                             rand_tmpl(), b == nbins - 1);
                end
            end
            calm = 0;
            drain();
        end

        $display("Sent %0d bins under %0d register writes; %0d frame results checked.",
                 bins_sent, cfg_writes, nll_sb.checked);
        if (nll_sb.errors == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
`default_nettype wire

FILE: filelist.f
rtl/ptnll_pkg.sv
rtl/ptnll_front.sv
rtl/ptnll_queue.sv
rtl/ptnll_back.sv
rtl/poisson_template_nll_unit.sv
bench/testbench.sv
